>>> rtl/countdown_entry_table_assert.svh
// ----------------------------------------------------------------------------
// Countdown entry table assertion macros
// Shorthand for the concurrent checks on the countdown entry table ports.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_ENTRY_TABLE_ASSERT_SVH
`define COUNTDOWN_ENTRY_TABLE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CET_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CET_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cet_pkg.sv
// ----------------------------------------------------------------------------
// Countdown entry table package
// Request and response types, operation and status codes, controller state
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cet_pkg;

	// Operation codes carried in a request.
	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_REMOVE  = 2'd2,
		OP_SORT    = 2'd3
	} cet_op_t;

	// Completion codes carried in a response.
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} cet_status_t;

	// One request on the command channel.
	typedef struct packed {
		cet_op_t            cmd;
		logic signed [15:0] amount;
		logic [15:0]        visitor_tag;
		logic [5:0]         index;
	} cet_cmd_t;

	// One response on the result channel.
	typedef struct packed {
		cet_status_t        status;
		logic [6:0]         entry_count;
		logic [15:0]        removed_tag;
		logic               head_valid;
		logic signed [15:0] head_duration;
		logic [15:0]        head_tag;
	} cet_rsp_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_ADV,
		S_RMV,
		S_SRT_START,
		S_SRT_SCAN,
		S_SRT_PUT,
		S_SRT_SWAP,
		S_FIN
	} cet_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic ins;
		logic set_full;
		logic set_bad;
		logic scan_start;
		logic scan;
		logic rm_done;
		logic put_best;
		logic put_base;
		logic finish;
	} cet_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cet_op_t op;
		logic    full;
		logic    bad_index;
		logic    scan_done;
		logic    pass_done;
		logic    rsp_free;
	} cet_stat_t;

endpackage

`default_nettype wire

>>> rtl/cet_ram.sv
// ----------------------------------------------------------------------------
// Countdown entry table RAM
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cet_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/cet_ctrl.sv
// ----------------------------------------------------------------------------
// Countdown entry table controller
// Sequences insert, advance, remove and the passes of the selection sort.
// ----------------------------------------------------------------------------
`default_nettype none

module cet_ctrl
	import cet_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	input  wire cet_stat_t stat,
	output cet_ctl_t       ctl,
	output logic           busy
);

	cet_state_t state_q;
	cet_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		ctl        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load   = 1'b1;
					state_next = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.op)
					OP_INSERT: begin
						if (stat.full) begin
							ctl.set_full = 1'b1;
						end else begin
							ctl.ins = 1'b1;
						end
						state_next = S_FIN;
					end
					OP_ADVANCE: begin
						ctl.scan_start = 1'b1;
						state_next     = S_ADV;
					end
					OP_REMOVE: begin
						if (stat.bad_index) begin
							ctl.set_bad = 1'b1;
							state_next  = S_FIN;
						end else begin
							ctl.scan_start = 1'b1;
							state_next     = S_RMV;
						end
					end
					OP_SORT: begin
						state_next = S_SRT_START;
					end
				endcase
			end
			S_ADV: begin
				ctl.scan = 1'b1;
				if (stat.scan_done) begin
					state_next = S_FIN;
				end
			end
			S_RMV: begin
				ctl.scan = 1'b1;
				if (stat.scan_done) begin
					ctl.rm_done = 1'b1;
					state_next  = S_FIN;
				end
			end
			S_SRT_START: begin
				if (stat.pass_done) begin
					state_next = S_FIN;
				end else begin
					ctl.scan_start = 1'b1;
					state_next     = S_SRT_SCAN;
				end
			end
			S_SRT_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.scan_done) begin
					state_next = S_SRT_PUT;
				end
			end
			S_SRT_PUT: begin
				ctl.put_best = 1'b1;
				state_next   = S_SRT_SWAP;
			end
			S_SRT_SWAP: begin
				ctl.put_base = 1'b1;
				state_next   = S_SRT_START;
			end
			S_FIN: begin
				if (stat.rsp_free) begin
					ctl.finish = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// A new request is taken only between operations.
	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/cet_datapath.sv
// ----------------------------------------------------------------------------
// Countdown entry table datapath
// Entry memory, count, scan pointer, sort bookkeeping, head copy and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module cet_datapath
	import cet_pkg::*;
#(
	parameter int TABLE_DEPTH   = 16,
	parameter int DURATION_BITS = 16,
	parameter int TAG_BITS      = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cet_ctl_t ctl,
	output cet_stat_t     stat,
	input  wire cet_cmd_t cmd_request,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output cet_rsp_t      rsp_request
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int DW = DURATION_BITS;
	localparam int TW = TAG_BITS;
	localparam int RW = DW + TW;
	localparam int EW = ((DW > 16) ? DW : 16) + 1;

	localparam logic signed [EW-1:0] DUR_MAX  = EW'((64'sd1 <<< (DW - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] DUR_MIN  = ~DUR_MAX;
	localparam logic signed [EW-1:0] HEAD_MAX = EW'(32767);
	localparam logic signed [EW-1:0] HEAD_MIN = ~HEAD_MAX;

	// Clamps a wide signed value to the stored duration range.
	function automatic logic [DW-1:0] sat_dur(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] c;
		if (v > DUR_MAX) begin
			c = DUR_MAX;
		end else if (v < DUR_MIN) begin
			c = DUR_MIN;
		end else begin
			c = v;
		end
		return c[DW-1:0];
	endfunction

	cet_cmd_t           req_q;
	cet_status_t        status_q;
	logic [15:0]        removed_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rd_ptr_q;
	logic [CW-1:0]      rd_start;
	logic               rd_hit;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_addr_s1;
	logic [RW-1:0]      rd_data;
	logic signed [DW-1:0] rd_dur;
	logic [TW-1:0]      rd_tag;
	logic [AW-1:0]      pass_q;
	logic [AW-1:0]      best_q;
	logic [RW-1:0]      best_ent_q;
	logic [RW-1:0]      base_ent_q;
	logic signed [DW-1:0] best_dur;
	logic [AW-1:0]      idx_a;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [RW-1:0]      wr_data;
	logic signed [DW-1:0] head_dur_q;
	logic [TW-1:0]      head_tag_q;
	logic signed [EW-1:0] head_ext;
	logic signed [EW-1:0] head_sat;
	logic               rsp_valid_q;
	cet_rsp_t           rsp_q;
	cet_rsp_t           rsp_next;

	assign rd_dur   = rd_data[RW-1:TW];
	assign rd_tag   = rd_data[TW-1:0];
	assign best_dur = best_ent_q[RW-1:TW];
	assign idx_a    = AW'(req_q.index);
	assign rd_hit   = (rd_ptr_q < count_q);

	// Scan start: remove begins at its index, sort at the current pass.
	always_comb begin
		if (req_q.cmd == OP_REMOVE) begin
			rd_start = CW'(req_q.index);
		end else if (req_q.cmd == OP_SORT) begin
			rd_start = CW'(pass_q);
		end else begin
			rd_start = '0;
		end
	end

	// Status back to the controller.
	always_comb begin
		stat.op        = req_q.cmd;
		stat.full      = (count_q == CW'(TABLE_DEPTH));
		stat.bad_index = ({1'b0, req_q.index} >= 7'(count_q));
		stat.scan_done = !rd_hit && !rd_vld_s1;
		stat.pass_done = ((CW + 1)'(pass_q) + (CW + 1)'(1)) >= (CW + 1)'(count_q);
		stat.rsp_free  = !rsp_valid_q || !rsp_stall;
	end

	// Write port selection.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		priority if (ctl.ins) begin
			wr_en   = 1'b1;
			wr_addr = count_q[AW-1:0];
			wr_data = {sat_dur(EW'(req_q.amount)), TW'(req_q.visitor_tag)};
		end else if (ctl.scan && rd_vld_s1 && (req_q.cmd == OP_ADVANCE)) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1;
			wr_data = {sat_dur(EW'(rd_dur) - EW'(req_q.amount)), rd_tag};
		end else if (ctl.scan && rd_vld_s1 && (req_q.cmd == OP_REMOVE) &&
				(rd_addr_s1 != idx_a)) begin
			// Later entries move down by one position.
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1 - AW'(1);
			wr_data = rd_data;
		end else if (ctl.put_best) begin
			wr_en   = 1'b1;
			wr_addr = pass_q;
			wr_data = best_ent_q;
		end else if (ctl.put_base) begin
			wr_en   = 1'b1;
			wr_addr = best_q;
			wr_data = base_ent_q;
		end else begin
			wr_en = 1'b0;
		end
	end

	cet_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_DEPTH)
	) u_cet_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (ctl.scan && rd_hit),
		.rd_addr(rd_ptr_q[AW-1:0]),
		.rd_data(rd_data)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.ins) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.rm_done) begin
				count_q <= count_q - CW'(1);
			end
			rd_vld_s1 <= ctl.scan && rd_hit;
			if (ctl.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request, scan and sort bookkeeping.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q     <= cmd_request;
			status_q  <= ST_DONE;
			removed_q <= '0;
			pass_q    <= '0;
		end
		if (ctl.set_full) begin
			status_q <= ST_FULL;
		end
		if (ctl.set_bad) begin
			status_q <= ST_BAD_INDEX;
		end
		if (ctl.scan_start) begin
			rd_ptr_q <= rd_start;
		end else if (ctl.scan && rd_hit) begin
			rd_ptr_q <= rd_ptr_q + CW'(1);
		end
		rd_addr_s1 <= rd_ptr_q[AW-1:0];
		if (ctl.scan && rd_vld_s1) begin
			if ((req_q.cmd == OP_REMOVE) && (rd_addr_s1 == idx_a)) begin
				removed_q <= 16'(rd_tag);
			end
			// The first strict minimum of the remaining entries wins.
			if (req_q.cmd == OP_SORT) begin
				if (rd_addr_s1 == pass_q) begin
					base_ent_q <= rd_data;
					best_ent_q <= rd_data;
					best_q     <= pass_q;
				end else if (rd_dur < best_dur) begin
					best_ent_q <= rd_data;
					best_q     <= rd_addr_s1;
				end
			end
		end
		if (ctl.put_base) begin
			pass_q <= pass_q + AW'(1);
		end
		// Keep a copy of position zero for the response.
		if (wr_en && (wr_addr == '0)) begin
			head_dur_q <= wr_data[RW-1:TW];
			head_tag_q <= wr_data[TW-1:0];
		end
		if (ctl.finish) begin
			rsp_q <= rsp_next;
		end
	end

	// Response assembly with the head duration clamped to sixteen bits.
	assign head_ext = EW'(head_dur_q);

	always_comb begin
		if (head_ext > HEAD_MAX) begin
			head_sat = HEAD_MAX;
		end else if (head_ext < HEAD_MIN) begin
			head_sat = HEAD_MIN;
		end else begin
			head_sat = head_ext;
		end
		rsp_next.status      = status_q;
		rsp_next.entry_count = 7'(count_q);
		rsp_next.removed_tag = removed_q;
		rsp_next.head_valid  = (count_q != '0);
		if (count_q != '0) begin
			rsp_next.head_duration = head_sat[15:0];
			rsp_next.head_tag      = 16'(head_tag_q);
		end else begin
			rsp_next.head_duration = '0;
			rsp_next.head_tag      = '0;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign rsp_request = rsp_q;

endmodule

`default_nettype wire

>>> rtl/countdown_entry_table.sv
// ----------------------------------------------------------------------------
// Countdown entry table
// Table of entries with a signed remaining duration and a tag; supports
// insert, advance, remove at index and selection sort by duration.
// ----------------------------------------------------------------------------
// One request is worked on at a time, and every request gives one response
// with the status, the entry count and the entry at position zero. Advance,
// remove and sort walk the entries through the single read port of the entry
// memory, one entry per cycle. A new request may be accepted while the
// previous response still waits to be taken.
`default_nettype none

module countdown_entry_table
	import cet_pkg::*;
#(
	parameter int TABLE_DEPTH   = 16,
	parameter int DURATION_BITS = 16,
	parameter int TAG_BITS      = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_stall,
	input  wire cet_cmd_t cmd_request,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output cet_rsp_t      rsp_request
);

	cet_ctl_t  ctl;
	cet_stat_t stat;

	// Operation sequencer.
	cet_ctrl u_cet_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.stat     (stat),
		.ctl      (ctl),
		.busy     (cmd_stall)
	);

	// Entry storage and arithmetic.
	cet_datapath #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.DURATION_BITS(DURATION_BITS),
		.TAG_BITS     (TAG_BITS)
	) u_cet_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.cmd_request(cmd_request),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_request(rsp_request)
	);

endmodule

`default_nettype wire

>>> rtl/cet_checker.sv
// ----------------------------------------------------------------------------
// Countdown entry table checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "countdown_entry_table_assert.svh"

module cet_checker
	import cet_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     rsp_valid,
	input wire logic     rsp_stall,
	input wire cet_rsp_t rsp_request
);

	// The count never goes beyond the table size.
	`CET_ASSERT_NOW(a_count_max, clk, arst_n, rsp_valid, rsp_request.entry_count <= 7'(TABLE_DEPTH), "entry count above table depth")

	// An invalid head means that no entries are held, and the head then reads as zero.
	`CET_ASSERT_NOW(a_head_empty, clk, arst_n, rsp_valid && !rsp_request.head_valid, (rsp_request.entry_count == 7'd0) && (rsp_request.head_duration == 16'sd0) && (rsp_request.head_tag == 16'd0), "empty head not cleared")

	// A failed request never reports a removed tag.
	`CET_ASSERT_NOW(a_err_no_tag, clk, arst_n, rsp_valid && (rsp_request.status != ST_DONE), rsp_request.removed_tag == 16'd0, "removed tag on failed request")

	// A dropped insert only happens on a full table.
	`CET_ASSERT_NOW(a_full_count, clk, arst_n, rsp_valid && (rsp_request.status == ST_FULL), rsp_request.entry_count == 7'(TABLE_DEPTH), "full status below table depth")

	// A stalled response holds.
	`CET_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_request), "stalled response changed")

endmodule

bind countdown_entry_table cet_checker #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_cet_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.rsp_request(rsp_request)
);

`default_nettype wire
